// ===== rtl/core/e2c_pkg.sv =====
`timescale 1ns / 1ps
// e2c_pkg: shared types, constants and tables for the epoch seconds to calendar block
// depends on nothing; imported by every module of the block

package e2c_pkg;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

    // reciprocals for the splits: 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15;
    // after the power-of-two shift, (n * recip) >> k is exact over each input range
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // ceil(2^35 / 675)
    localparam logic [13:0] HOUR_RECIP = 14'd9321;      // ceil(2^21 / 225)
    localparam logic [10:0] MIN_RECIP  = 11'd1093;      // ceil(2^14 / 15)

    localparam int          BASE_YEAR_INT = 1970;
    localparam logic [11:0] BASE_YEAR     = 12'(BASE_YEAR_INT);
    localparam logic [6:0]  BASE_MOD100   = 7'(BASE_YEAR_INT % 100);
    localparam logic [8:0]  BASE_MOD400   = 9'(BASE_YEAR_INT % 400);
    // 1970-01-01 was a thursday
    localparam logic [2:0]  BASE_WEEKDAY  = 3'd4;
    localparam logic [3:0]  LAST_MONTH    = 4'd12;

    // time split commands, one registered step each
    typedef logic [2:0] div_cmd_t;
    localparam div_cmd_t DIV_IDLE = 3'd0;  // hold
    localparam div_cmd_t DIV_LOAD = 3'd1;  // take the count, days from it
    localparam div_cmd_t DIV_SOD  = 3'd2;  // seconds of day
    localparam div_cmd_t DIV_HOUR = 3'd3;
    localparam div_cmd_t DIV_SOH  = 3'd4;  // seconds of hour
    localparam div_cmd_t DIV_MIN  = 3'd5;
    localparam div_cmd_t DIV_SEC  = 3'd6;

    typedef struct packed {
        logic load;
        logic year_step;
        logic month_step;
    } cal_cmd_t;

    typedef struct packed {
        logic year_more;
        logic month_more;
    } cal_stat_t;

    // days in a month, february taking 29 in leap years
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        begin
            case (month)
                4'd2:    len = leap ? 5'd29 : 5'd28;
                4'd4:    len = 5'd30;
                4'd6:    len = 5'd30;
                4'd9:    len = 5'd30;
                4'd11:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// ===== rtl/core/e2c_div.sv =====
`timescale 1ns / 1ps
// e2c_div: splits seconds into days, hours, minutes and seconds by reciprocal multiplies
// depends on e2c_pkg; one registered step per command from e2c_ctrl

module e2c_div
    import e2c_pkg::*;
(
    input  logic        clk,
    input  div_cmd_t    cmd,
    input  logic [31:0] count_seconds,
    output logic [15:0] days,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);

    logic [16:0] low_reg, low_next;
    logic [15:0] days_reg, days_next;
    logic [16:0] sod_reg, sod_next;
    logic [4:0]  hour_reg, hour_next;
    logic [11:0] soh_reg, soh_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;
    logic [50:0] days_prod;
    logic [16:0] day_start;
    logic [25:0] hour_prod;
    logic [11:0] hour_start;
    logic [19:0] min_prod;
    logic [5:0]  min_start;

    assign days_prod  = 51'(count_seconds[31:7]) * 51'(DAY_RECIP);
    // remainders are taken in low bits only, each true difference fits them
    assign day_start  = 17'(days_reg) * SECS_PER_DAY;
    assign hour_prod  = 26'(sod_reg[16:4]) * 26'(HOUR_RECIP);
    assign hour_start = 12'(hour_reg) * SECS_PER_HOUR;
    assign min_prod   = 20'(soh_reg[11:2]) * 20'(MIN_RECIP);
    assign min_start  = min_reg * SECS_PER_MIN;

    always_comb
    begin
        low_next  = low_reg;
        days_next = days_reg;
        sod_next  = sod_reg;
        hour_next = hour_reg;
        soh_next  = soh_reg;
        min_next  = min_reg;
        sec_next  = sec_reg;
        case (cmd)
            DIV_LOAD:
            begin
                low_next  = count_seconds[16:0];
                days_next = days_prod[50:35];
            end
            DIV_SOD:  sod_next  = low_reg - day_start;
            DIV_HOUR: hour_next = hour_prod[25:21];
            DIV_SOH:  soh_next  = sod_reg[11:0] - hour_start;
            DIV_MIN:  min_next  = min_prod[19:14];
            DIV_SEC:  sec_next  = soh_reg[5:0] - min_start;
            default:
            begin
                low_next = low_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        low_reg  <= low_next;
        days_reg <= days_next;
        sod_reg  <= sod_next;
        hour_reg <= hour_next;
        soh_reg  <= soh_next;
        min_reg  <= min_next;
        sec_reg  <= sec_next;
    end

    assign days   = days_reg;
    assign hour   = hour_reg;
    assign minute = min_reg;
    assign second = sec_reg;

endmodule

// ===== rtl/core/e2c_cal.sv =====
`timescale 1ns / 1ps
// e2c_cal: year and month walk over the day count, weekday kept mod 7 on the way
// depends on e2c_pkg; stepped by e2c_ctrl

module e2c_cal
    import e2c_pkg::*;
(
    input  logic        clk,
    input  cal_cmd_t    cmd,
    input  logic [15:0] days_in,
    output cal_stat_t   stat,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [2:0]  weekday
);

    logic [11:0] year_reg, year_next;
    logic [6:0]  mod100_reg, mod100_next;
    logic [8:0]  mod400_reg, mod400_next;
    logic [15:0] days_reg, days_next;
    logic [3:0]  month_reg, month_next;
    logic [2:0]  wday_reg, wday_next;
    logic        leap;
    logic [8:0]  year_len;
    logic [4:0]  mlen;
    logic [4:0]  mlen_extra;

    function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
        logic [3:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, b};
            if (sum >= 4'd7)
                sum = sum - 4'd7;
            return sum[2:0];
        end
    endfunction

    function automatic logic [2:0] mod7_small(input logic [5:0] v);
        logic [5:0] r;
        begin
            r = v;
            for (int i = 0; i < 5; i++)
            begin
                if (r >= 6'd7)
                    r = r - 6'd7;
            end
            return r[2:0];
        end
    endfunction

    // leap under the 4/100/400 rule
    assign leap     = (year_reg[1:0] == 2'b00) && ((mod100_reg != 7'd0) || (mod400_reg == 9'd0));
    assign year_len = leap ? 9'd366 : 9'd365;
    assign mlen     = month_len(month_reg, leap);
    // month length mod 7
    assign mlen_extra = mlen - 5'd28;

    assign stat.year_more  = days_reg >= {7'd0, year_len};
    assign stat.month_more = (month_reg != LAST_MONTH) && (days_reg >= {11'd0, mlen});

    always_comb
    begin
        year_next   = year_reg;
        mod100_next = mod100_reg;
        mod400_next = mod400_reg;
        days_next   = days_reg;
        month_next  = month_reg;
        wday_next   = wday_reg;
        if (cmd.load)
        begin
            year_next   = BASE_YEAR;
            mod100_next = BASE_MOD100;
            mod400_next = BASE_MOD400;
            days_next   = days_in;
            month_next  = 4'd1;
            wday_next   = BASE_WEEKDAY;
        end
        else if (cmd.year_step)
        begin
            days_next   = days_reg - {7'd0, year_len};
            year_next   = year_reg + 12'd1;
            mod100_next = (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
            mod400_next = (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
            wday_next   = add_mod7(wday_reg, leap ? 3'd2 : 3'd1);
        end
        else if (cmd.month_step)
        begin
            days_next  = days_reg - {11'd0, mlen};
            month_next = month_reg + 4'd1;
            wday_next  = add_mod7(wday_reg, mlen_extra[2:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg   <= year_next;
        mod100_reg <= mod100_next;
        mod400_reg <= mod400_next;
        days_reg   <= days_next;
        month_reg  <= month_next;
        wday_reg   <= wday_next;
    end

    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = days_reg[4:0] + 5'd1;
    assign weekday      = mod7_small({3'd0, wday_reg} + {1'b0, days_reg[4:0]});

endmodule

// ===== rtl/core/e2c_ctrl.sv =====
`timescale 1ns / 1ps
// e2c_ctrl: sequencer for the time split and the calendar walk
// depends on e2c_pkg; drives e2c_div and e2c_cal

module e2c_ctrl
    import e2c_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_full,
    input  logic      out_ready,
    input  cal_stat_t cal_stat,
    output div_cmd_t  div_cmd,
    output cal_cmd_t  cal_cmd,
    output logic      publish
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SOD    = 3'd1;
    localparam logic [2:0] S_HOUR   = 3'd2;
    localparam logic [2:0] S_SOH    = 3'd3;
    localparam logic [2:0] S_MIN    = 3'd4;
    localparam logic [2:0] S_SEC    = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    localparam logic [1:0] W_YEAR  = 2'd0;
    localparam logic [1:0] W_MONTH = 2'd1;
    localparam logic [1:0] W_DONE  = 2'd2;

    logic [2:0] state_reg, state_next;
    logic [1:0] walk_reg, walk_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        div_cmd    = DIV_IDLE;
        cal_cmd    = '0;
        publish    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    div_cmd    = DIV_LOAD;
                    state_next = S_SOD;
                end
            end
            S_SOD:
            begin
                div_cmd      = DIV_SOD;
                cal_cmd.load = 1'b1;
                state_next   = S_HOUR;
            end
            S_HOUR:
            begin
                div_cmd    = DIV_HOUR;
                state_next = S_SOH;
            end
            S_SOH:
            begin
                div_cmd    = DIV_SOH;
                state_next = S_MIN;
            end
            S_MIN:
            begin
                div_cmd    = DIV_MIN;
                state_next = S_SEC;
            end
            S_SEC:
            begin
                div_cmd    = DIV_SEC;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if ((walk_reg == W_DONE) && (!out_full || out_ready))
                begin
                    publish    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // calendar walk runs beside the time split
        walk_next = walk_reg;
        if (state_reg == S_SOD)
            walk_next = W_YEAR;
        else
        begin
            case (walk_reg)
                W_YEAR:
                begin
                    if (cal_stat.year_more)
                        cal_cmd.year_step = 1'b1;
                    else
                        walk_next = W_MONTH;
                end
                W_MONTH:
                begin
                    if (cal_stat.month_more)
                        cal_cmd.month_step = 1'b1;
                    else
                        walk_next = W_DONE;
                end
                W_DONE:
                begin
                    walk_next = W_DONE;
                end
                default:
                begin
                    walk_next = W_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            walk_reg  <= W_DONE;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
        end
    end

endmodule

// ===== rtl/core/epoch_seconds_to_calendar_top.sv =====
`timescale 1ns / 1ps
// epoch_seconds_to_calendar_top: seconds since 1970-01-01 to gregorian date, time and weekday
// depends on e2c_pkg, e2c_ctrl, e2c_div and e2c_cal

// One word in, one word out. An input word is a 32-bit count of seconds since
// 1970-01-01 00:00:00; the result word gives year, month, day, hour, minute,
// second and weekday (0 is sunday). The block works on one word at a time. On
// the accepting edge the count is captured and split into days by a reciprocal
// multiply; five more steps give seconds of day, hour, seconds of hour, minute
// and second. At the first of those steps the calendar unit takes the day
// count, then walks it one year per cycle (up to 136 years from 1970), then one
// month per cycle, with a turn step after each walk. A result is published
// once the time split and the walk are both done and the output register can
// take it; the walk is longest for dates late in 2105 (135 year steps and 11
// month steps). The next word can be taken in the cycle after publishing. The
// result sits in an output register, so a new word is taken while the last
// result still waits to be read; the following result then waits inside and
// input stalls until the output register is emptied.

module epoch_seconds_to_calendar_top
    import e2c_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] count_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] calendar_year,
    output logic [3:0]  calendar_month,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour_of_day,
    output logic [5:0]  minute_of_hour,
    output logic [5:0]  second_of_minute,
    output logic [2:0]  weekday
);

    div_cmd_t    div_cmd;
    cal_cmd_t    cal_cmd;
    cal_stat_t   cal_stat;
    logic        publish;

    // datapath results
    logic [15:0] dp_days;
    logic [4:0]  dp_hour;
    logic [5:0]  dp_minute;
    logic [5:0]  dp_second;
    logic [11:0] dp_year;
    logic [3:0]  dp_month;
    logic [4:0]  dp_day;
    logic [2:0]  dp_weekday;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic [2:0]  weekday_reg;

    e2c_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_full  (out_valid_reg),
        .out_ready (out_ready),
        .cal_stat  (cal_stat),
        .div_cmd   (div_cmd),
        .cal_cmd   (cal_cmd),
        .publish   (publish)
    );

    // seconds -> days, hours, minutes, seconds
    e2c_div u_div
    (
        .clk           (clk),
        .cmd           (div_cmd),
        .count_seconds (count_seconds),
        .days          (dp_days),
        .hour          (dp_hour),
        .minute        (dp_minute),
        .second        (dp_second)
    );

    // days -> year, month, day, weekday
    e2c_cal u_cal
    (
        .clk          (clk),
        .cmd          (cal_cmd),
        .days_in      (dp_days),
        .stat         (cal_stat),
        .year         (dp_year),
        .month        (dp_month),
        .day_of_month (dp_day),
        .weekday      (dp_weekday)
    );

    // full once a result is published, empty once it is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (publish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (publish)
        begin
            year_reg    <= dp_year;
            month_reg   <= dp_month;
            day_reg     <= dp_day;
            hour_reg    <= dp_hour;
            minute_reg  <= dp_minute;
            second_reg  <= dp_second;
            weekday_reg <= dp_weekday;
        end
    end

    assign out_valid        = out_valid_reg;
    assign calendar_year    = year_reg;
    assign calendar_month   = month_reg;
    assign day_of_month     = day_reg;
    assign hour_of_day      = hour_reg;
    assign minute_of_hour   = minute_reg;
    assign second_of_minute = second_reg;
    assign weekday          = weekday_reg;

endmodule
